// ----- rtl/rpo_pkg.sv -----
// ----------------------------------------------------------------------------
// rpo_pkg
// Shared types and constants for the radial point offset pipeline.
// ----------------------------------------------------------------------------
package rpo_pkg;

    localparam int Q_SHIFT     = 16;
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 17;
    localparam int LANES       = 3;

    // configuration register indexes
    localparam logic [1:0] REG_AXIS_X = 2'd0;
    localparam logic [1:0] REG_AXIS_Y = 2'd1;
    localparam logic [1:0] REG_AXIS_Z = 2'd2;
    localparam logic [1:0] REG_SHIFT  = 2'd3;

    typedef logic signed [31:0] coord_t;
    typedef logic signed [17:0] axis_t;
    typedef logic [30:0]        qmag_t;

    // per-item data carried alongside the root and divide stages
    typedef struct packed {
        logic     action;
        coord_t   px;
        coord_t   py;
        coord_t   pz;
        logic [2:0] neg;
        qmag_t    qx;
        qmag_t    qy;
        qmag_t    qz;
    } side_t;

endpackage

// ----- rtl/rpo_front.sv -----
// ----------------------------------------------------------------------------
// rpo_front
// Projection onto the axis, radial vector, range reduction and squared length.
// ----------------------------------------------------------------------------
module rpo_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic            action,
    input  rpo_pkg::coord_t p_x,
    input  rpo_pkg::coord_t p_y,
    input  rpo_pkg::coord_t p_z,
    input  rpo_pkg::axis_t  a_x,
    input  rpo_pkg::axis_t  a_y,
    input  rpo_pkg::axis_t  a_z,
    output logic            out_valid,
    output rpo_pkg::side_t  out_side,
    output logic [63:0]     out_sum
);

    rpo_pkg::axis_t a [rpo_pkg::LANES];
    rpo_pkg::coord_t p_in [rpo_pkg::LANES];

    logic [7:0] v_reg;
    logic [7:0] v_next;
    logic [7:0] act_reg;

    // point travels through every stage
    rpo_pkg::coord_t p1_reg [rpo_pkg::LANES];
    rpo_pkg::coord_t p2_reg [rpo_pkg::LANES];
    rpo_pkg::coord_t p3_reg [rpo_pkg::LANES];
    rpo_pkg::coord_t p4_reg [rpo_pkg::LANES];
    rpo_pkg::coord_t p5_reg [rpo_pkg::LANES];
    rpo_pkg::coord_t p6_reg [rpo_pkg::LANES];
    rpo_pkg::coord_t p7_reg [rpo_pkg::LANES];
    rpo_pkg::coord_t p8_reg [rpo_pkg::LANES];

    logic signed [49:0] prod_reg [rpo_pkg::LANES];
    logic signed [49:0] prod_next [rpo_pkg::LANES];
    logic signed [35:0] dot_reg;
    logic signed [35:0] dot_next;
    logic signed [51:0] dsum;
    logic signed [53:0] dp_reg [rpo_pkg::LANES];
    logic signed [53:0] dp_next [rpo_pkg::LANES];
    logic signed [38:0] r_reg [rpo_pkg::LANES];
    logic signed [38:0] r_next [rpo_pkg::LANES];
    logic signed [37:0] proj [rpo_pkg::LANES];
    logic [38:0] mag_reg [rpo_pkg::LANES];
    logic [38:0] mag_next [rpo_pkg::LANES];
    logic [2:0]  neg5_reg;
    logic [2:0]  neg5_next;
    logic [2:0]  neg6_reg;
    logic [2:0]  neg7_reg;
    logic [2:0]  neg8_reg;
    logic [38:0] ormag;
    logic [3:0]  s_reg;
    logic [3:0]  s_next;
    rpo_pkg::qmag_t q6_reg [rpo_pkg::LANES];
    rpo_pkg::qmag_t q6_next [rpo_pkg::LANES];
    rpo_pkg::qmag_t q7_reg [rpo_pkg::LANES];
    rpo_pkg::qmag_t q8_reg [rpo_pkg::LANES];
    logic [61:0] sq_reg [rpo_pkg::LANES];
    logic [61:0] sq_next [rpo_pkg::LANES];
    logic [63:0] sum_reg;
    logic [63:0] sum_next;

    assign a[0] = a_x;
    assign a[1] = a_y;
    assign a[2] = a_z;
    assign p_in[0] = p_x;
    assign p_in[1] = p_y;
    assign p_in[2] = p_z;

    assign v_next = {v_reg[6:0], in_valid};

    always_comb
    begin
        for (int i = 0; i < rpo_pkg::LANES; i++)
        begin
            prod_next[i] = p_in[i] * a[i];
        end
        dsum = 52'(prod_reg[0]) + 52'(prod_reg[1]) + 52'(prod_reg[2]);
        dot_next = 36'(dsum >>> rpo_pkg::Q_SHIFT);
        for (int i = 0; i < rpo_pkg::LANES; i++)
        begin
            dp_next[i] = dot_reg * a[i];
            proj[i]    = 38'(dp_reg[i] >>> rpo_pkg::Q_SHIFT);
            r_next[i]  = 39'(p3_reg[i]) - 39'(proj[i]);
            mag_next[i] = r_reg[i][38] ? 39'(-r_reg[i]) : 39'(r_reg[i]);
            neg5_next[i] = r_reg[i][38];
        end
        ormag = mag_next[0] | mag_next[1] | mag_next[2];
        s_next = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (ormag[31 + i])
            begin
                s_next = 4'(i + 1);
            end
        end
        for (int i = 0; i < rpo_pkg::LANES; i++)
        begin
            q6_next[i] = 31'(mag_reg[i] >> s_reg);
            sq_next[i] = 62'(q6_reg[i]) * 62'(q6_reg[i]);
        end
        sum_next = 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            act_reg  <= {act_reg[6:0], action};
            prod_reg <= prod_next;
            dot_reg  <= dot_next;
            dp_reg   <= dp_next;
            r_reg    <= r_next;
            mag_reg  <= mag_next;
            neg5_reg <= neg5_next;
            neg6_reg <= neg5_reg;
            neg7_reg <= neg6_reg;
            neg8_reg <= neg7_reg;
            s_reg    <= s_next;
            q6_reg   <= q6_next;
            q7_reg   <= q6_reg;
            q8_reg   <= q7_reg;
            sq_reg   <= sq_next;
            sum_reg  <= sum_next;
            p1_reg   <= p_in;
            p2_reg   <= p1_reg;
            p3_reg   <= p2_reg;
            p4_reg   <= p3_reg;
            p5_reg   <= p4_reg;
            p6_reg   <= p5_reg;
            p7_reg   <= p6_reg;
            p8_reg   <= p7_reg;
        end
    end

    assign out_valid       = v_reg[7];
    assign out_sum         = sum_reg;
    assign out_side.action = act_reg[7];
    assign out_side.px     = p8_reg[0];
    assign out_side.py     = p8_reg[1];
    assign out_side.pz     = p8_reg[2];
    assign out_side.neg    = neg8_reg;
    assign out_side.qx     = q8_reg[0];
    assign out_side.qy     = q8_reg[1];
    assign out_side.qz     = q8_reg[2];

endmodule

// ----- rtl/rpo_sqrt.sv -----
// ----------------------------------------------------------------------------
// rpo_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rpo_sqrt
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  rpo_pkg::side_t in_side,
    input  logic [63:0]    in_sum,
    output logic           out_valid,
    output rpo_pkg::side_t out_side,
    output logic [31:0]    out_len
);

    logic [rpo_pkg::SQRT_STAGES-1:0] v_reg;
    logic [63:0]    n_reg    [rpo_pkg::SQRT_STAGES];
    logic [63:0]    n_next   [rpo_pkg::SQRT_STAGES];
    logic [63:0]    res_reg  [rpo_pkg::SQRT_STAGES];
    logic [63:0]    res_next [rpo_pkg::SQRT_STAGES];
    rpo_pkg::side_t side_reg [rpo_pkg::SQRT_STAGES];

    always_comb
    begin
        logic [63:0] n_prev;
        logic [63:0] res_prev;
        logic [63:0] bitv;
        for (int k = 0; k < rpo_pkg::SQRT_STAGES; k++)
        begin
            n_prev   = (k == 0) ? in_sum : n_reg[(k == 0) ? 0 : k - 1];
            res_prev = (k == 0) ? 64'd0  : res_reg[(k == 0) ? 0 : k - 1];
            bitv     = 64'd1 << (62 - 2 * k);
            if (n_prev >= res_prev + bitv)
            begin
                n_next[k]   = n_prev - (res_prev + bitv);
                res_next[k] = (res_prev >> 1) + bitv;
            end
            else
            begin
                n_next[k]   = n_prev;
                res_next[k] = res_prev >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[rpo_pkg::SQRT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg       <= n_next;
            res_reg     <= res_next;
            side_reg[0] <= in_side;
            for (int k = 1; k < rpo_pkg::SQRT_STAGES; k++)
            begin
                side_reg[k] <= side_reg[k - 1];
            end
        end
    end

    assign out_valid = v_reg[rpo_pkg::SQRT_STAGES-1];
    assign out_side  = side_reg[rpo_pkg::SQRT_STAGES-1];
    assign out_len   = res_reg[rpo_pkg::SQRT_STAGES-1][31:0];

endmodule

// ----- rtl/rpo_div.sv -----
// ----------------------------------------------------------------------------
// rpo_div
// Three-lane pipelined restoring divider: |q| * 2^16 / len, one bit per stage.
// ----------------------------------------------------------------------------
module rpo_div
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  rpo_pkg::side_t in_side,
    input  logic [31:0]    in_len,
    output logic           out_valid,
    output rpo_pkg::side_t out_side,
    output logic           out_zero,
    output logic [16:0]    out_u [rpo_pkg::LANES]
);

    localparam int N = rpo_pkg::DIV_STAGES;

    logic [N-1:0]   v_reg;
    rpo_pkg::side_t side_reg [N];
    logic [31:0]    len_reg  [N];
    logic [47:0]    rem_reg  [N][rpo_pkg::LANES];
    logic [47:0]    rem_next [N][rpo_pkg::LANES];
    logic [16:0]    quo_reg  [N][rpo_pkg::LANES];
    logic [16:0]    quo_next [N][rpo_pkg::LANES];
    logic [47:0]    num_in   [rpo_pkg::LANES];

    assign num_in[0] = {1'b0, in_side.qx, 16'd0};
    assign num_in[1] = {1'b0, in_side.qy, 16'd0};
    assign num_in[2] = {1'b0, in_side.qz, 16'd0};

    always_comb
    begin
        logic [47:0] rem_prev;
        logic [16:0] quo_prev;
        logic [47:0] dsh;
        for (int k = 0; k < N; k++)
        begin
            for (int l = 0; l < rpo_pkg::LANES; l++)
            begin
                rem_prev = (k == 0) ? num_in[l] : rem_reg[(k == 0) ? 0 : k - 1][l];
                quo_prev = (k == 0) ? 17'd0 : quo_reg[(k == 0) ? 0 : k - 1][l];
                dsh = {16'd0, ((k == 0) ? in_len : len_reg[(k == 0) ? 0 : k - 1])}
                      << (N - 1 - k);
                if (rem_prev >= dsh)
                begin
                    rem_next[k][l] = rem_prev - dsh;
                    quo_next[k][l] = {quo_prev[15:0], 1'b1};
                end
                else
                begin
                    rem_next[k][l] = rem_prev;
                    quo_next[k][l] = {quo_prev[15:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg     <= rem_next;
            quo_reg     <= quo_next;
            side_reg[0] <= in_side;
            len_reg[0]  <= in_len;
            for (int k = 1; k < N; k++)
            begin
                side_reg[k] <= side_reg[k - 1];
                len_reg[k]  <= len_reg[k - 1];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_side  = side_reg[N-1];
    assign out_zero  = (len_reg[N-1] == 32'd0);
    assign out_u     = quo_reg[N-1];

endmodule

// ----- rtl/radial_point_offset.sv -----
// ----------------------------------------------------------------------------
// radial_point_offset
// Moves a Q16.16 point radially away from or toward a unit axis through
// the origin by a configured distance, with 32-bit saturation.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+-----------------------------------------------------
//  s_*      | in        | tdata: point_x, point_y, point_z; tuser: action
//  m_*      | out       | tdata: moved_x, moved_y, moved_z; tuser: on_axis, saturated
//  cfg_*    | in        | write of axis_x, axis_y, axis_z, shift_distance
//
// One item per cycle sustained while the output is not stalled, through
// 8 projection and squaring stages, 32 square root stages (one root bit
// each), 17 divide stages (one quotient bit each), one scale multiply
// stage and the output register. Reset clears the valid bits and the
// configuration registers. A stall on the output freezes every stage at
// once, so no item is lost or repeated; the input side is ready whenever
// the output register is empty or being taken.
// ----------------------------------------------------------------------------
module radial_point_offset
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,    // point_x, point_y, point_z
    input  logic         s_tuser,    // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,    // moved_x, moved_y, moved_z
    output logic [1:0]   m_tuser,    // on_axis, saturated
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);

    rpo_pkg::axis_t  axis_x_reg;
    rpo_pkg::axis_t  axis_y_reg;
    rpo_pkg::axis_t  axis_z_reg;
    rpo_pkg::coord_t shift_reg;

    logic en;

    logic           f_valid;
    rpo_pkg::side_t f_side;
    logic [63:0]    f_sum;
    logic           r_valid;
    rpo_pkg::side_t r_side;
    logic [31:0]    r_len;
    logic           d_valid;
    rpo_pkg::side_t d_side;
    logic           d_zero;
    logic [16:0]    d_u [rpo_pkg::LANES];

    // scale stage
    logic                  sc_valid_reg;
    rpo_pkg::side_t        sc_side_reg;
    logic                  sc_zero_reg;
    logic signed [49:0]    sc_prod_reg  [rpo_pkg::LANES];
    logic signed [49:0]    sc_prod_next [rpo_pkg::LANES];
    logic signed [17:0]    u_signed     [rpo_pkg::LANES];

    // output stage
    logic                  m_valid_reg;
    logic [95:0]           m_data_reg;
    logic [95:0]           m_data_next;
    logic [1:0]            m_user_reg;
    logic [1:0]            m_user_next;
    rpo_pkg::coord_t       p_sc [rpo_pkg::LANES];
    logic signed [33:0]    off  [rpo_pkg::LANES];
    logic signed [34:0]    mv   [rpo_pkg::LANES];
    rpo_pkg::coord_t       mv_sat [rpo_pkg::LANES];
    logic                  sat_any;

    // Advance the whole pipeline unless a finished item is stuck at the output.
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_x_reg <= '0;
            axis_y_reg <= '0;
            axis_z_reg <= '0;
            shift_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                rpo_pkg::REG_AXIS_X: axis_x_reg <= cfg_wdata[17:0];
                rpo_pkg::REG_AXIS_Y: axis_y_reg <= cfg_wdata[17:0];
                rpo_pkg::REG_AXIS_Z: axis_z_reg <= cfg_wdata[17:0];
                rpo_pkg::REG_SHIFT:  shift_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    rpo_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid && s_tready),
        .action    (s_tuser),
        .p_x       (s_tdata[31:0]),
        .p_y       (s_tdata[63:32]),
        .p_z       (s_tdata[95:64]),
        .a_x       (axis_x_reg),
        .a_y       (axis_y_reg),
        .a_z       (axis_z_reg),
        .out_valid (f_valid),
        .out_side  (f_side),
        .out_sum   (f_sum)
    );

    rpo_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_side   (f_side),
        .in_sum    (f_sum),
        .out_valid (r_valid),
        .out_side  (r_side),
        .out_len   (r_len)
    );

    rpo_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r_valid),
        .in_side   (r_side),
        .in_len    (r_len),
        .out_valid (d_valid),
        .out_side  (d_side),
        .out_zero  (d_zero),
        .out_u     (d_u)
    );

    // Apply the radial sign to the unit component, then scale by the distance.
    always_comb
    begin
        for (int i = 0; i < rpo_pkg::LANES; i++)
        begin
            u_signed[i]     = d_side.neg[i] ? -$signed({1'b0, d_u[i]})
                                            : $signed({1'b0, d_u[i]});
            sc_prod_next[i] = u_signed[i] * shift_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            sc_valid_reg <= d_valid;
            m_valid_reg  <= sc_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_side_reg <= d_side;
            sc_zero_reg <= d_zero;
            sc_prod_reg <= sc_prod_next;
            m_data_reg  <= m_data_next;
            m_user_reg  <= m_user_next;
        end
    end

    // Add or subtract the offset and clamp to 32 bits; on the axis pass the point.
    always_comb
    begin
        p_sc[0] = sc_side_reg.px;
        p_sc[1] = sc_side_reg.py;
        p_sc[2] = sc_side_reg.pz;
        sat_any = 1'b0;
        for (int i = 0; i < rpo_pkg::LANES; i++)
        begin
            off[i] = 34'(sc_prod_reg[i] >>> rpo_pkg::Q_SHIFT);
            mv[i]  = sc_side_reg.action ? 35'(p_sc[i]) - 35'(off[i])
                                        : 35'(p_sc[i]) + 35'(off[i]);
            if (mv[i] > 35'sd2147483647)
            begin
                mv_sat[i] = 32'sh7FFFFFFF;
                sat_any   = 1'b1;
            end
            else if (mv[i] < -35'sd2147483648)
            begin
                mv_sat[i] = 32'sh80000000;
                sat_any   = 1'b1;
            end
            else
            begin
                mv_sat[i] = mv[i][31:0];
            end
        end
        if (sc_zero_reg)
        begin
            m_data_next = {p_sc[2], p_sc[1], p_sc[0]};
            m_user_next = 2'b01;
        end
        else
        begin
            m_data_next = {mv_sat[2], mv_sat[1], mv_sat[0]};
            m_user_next = {sat_any, 1'b0};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ----- sim/rpo_checker.sv -----
// ----------------------------------------------------------------------------
// rpo_checker
// Watches the point stream, the result stream and the register writes of the
// radial point offset block, predicts each result and compares it field by
// field with what the block delivers.
// ----------------------------------------------------------------------------
module rpo_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [95:0]  s_tdata,    // point_x, point_y, point_z
    input  logic         s_tuser,    // action
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [95:0]  m_tdata,    // moved_x, moved_y, moved_z
    input  logic [1:0]   m_tuser,    // on_axis, saturated
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata,
    output int           pending,
    output int           fails
);

    typedef struct packed {
        rpo_pkg::coord_t mx;
        rpo_pkg::coord_t my;
        rpo_pkg::coord_t mz;
        logic   on_axis;
        logic   sat;
    } moved_t;

    rpo_pkg::axis_t  ax_reg, ay_reg, az_reg;
    rpo_pkg::coord_t dist_reg;
    moved_t moved_q[$];

    function automatic moved_t offset_point(logic retract, logic [95:0] pt);
        longint p[3];
        longint a[3];
        longint r[3];
        longint dotp, u, off, v, qs;
        longint unsigned rmag[3];
        longint unsigned mx, qm, total, rem, res, bitv;
        int s;
        moved_t o;
        p[0] = longint'(rpo_pkg::coord_t'(pt[31:0]));
        p[1] = longint'(rpo_pkg::coord_t'(pt[63:32]));
        p[2] = longint'(rpo_pkg::coord_t'(pt[95:64]));
        a[0] = longint'(ax_reg);
        a[1] = longint'(ay_reg);
        a[2] = longint'(az_reg);
        dotp = (p[0] * a[0] + p[1] * a[1] + p[2] * a[2]) >>> rpo_pkg::Q_SHIFT;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            r[i] = p[i] - ((dotp * a[i]) >>> rpo_pkg::Q_SHIFT);
            rmag[i] = (r[i] < 0) ? -r[i] : r[i];
            if (rmag[i] > mx)
                mx = rmag[i];
        end
        s = 0;
        while ((mx >> s) >= 64'h8000_0000)
            s++;
        total = 0;
        for (int i = 0; i < 3; i++)
        begin
            qm = rmag[i] >> s;
            total += qm * qm;
        end
        // bitwise integer square root, floor
        rem = total;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (rem >= res + bitv)
            begin
                rem -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        o.sat = 1'b0;
        o.on_axis = (res == 0);
        for (int i = 0; i < 3; i++)
        begin
            if (res == 0)
                v = p[i];
            else
            begin
                qs = longint'(rmag[i] >> s);
                if (r[i] < 0)
                    qs = -qs;
                u = (qs * 65536) / longint'(res);
                off = (u * longint'(dist_reg)) >>> rpo_pkg::Q_SHIFT;
                v = retract ? p[i] - off : p[i] + off;
                if (v > 64'sd2147483647)
                begin
                    v = 64'sd2147483647;
                    o.sat = 1'b1;
                end
                else if (v < -64'sd2147483648)
                begin
                    v = -64'sd2147483648;
                    o.sat = 1'b1;
                end
            end
            case (i)
                0: o.mx = v[31:0];
                1: o.my = v[31:0];
                default: o.mz = v[31:0];
            endcase
        end
        return o;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            fails++;
            $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
        end
    endtask

    assign pending = moved_q.size();

    initial fails = 0;

    always @(posedge clk or negedge rst_n)
    begin
        moved_t want;
        if (!rst_n)
        begin
            ax_reg = '0;
            ay_reg = '0;
            az_reg = '0;
            dist_reg = '0;
            moved_q.delete();
        end
        else
        begin
            // registers only change while the pipe is empty
            if (cfg_we)
            begin
                case (cfg_addr)
                    rpo_pkg::REG_AXIS_X: ax_reg = cfg_wdata[17:0];
                    rpo_pkg::REG_AXIS_Y: ay_reg = cfg_wdata[17:0];
                    rpo_pkg::REG_AXIS_Z: az_reg = cfg_wdata[17:0];
                    rpo_pkg::REG_SHIFT:  dist_reg = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (moved_q.size() == 0)
                begin
                    fails++;
                    $display("%0t unexpected item: expected none actual %h %b",
                             $time, m_tdata, m_tuser);
                end
                else
                begin
                    want = moved_q.pop_front();
                    compare_field("moved_x", want.mx, m_tdata[31:0]);
                    compare_field("moved_y", want.my, m_tdata[63:32]);
                    compare_field("moved_z", want.mz, m_tdata[95:64]);
                    compare_field("on_axis", 32'(want.on_axis), 32'(m_tuser[0]));
                    compare_field("saturated", 32'(want.sat), 32'(m_tuser[1]));
                end
            end
            if (s_tvalid && s_tready)
                moved_q.insert(moved_q.size(), offset_point(s_tuser, s_tdata));
        end
    end

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives points through the radial point offset block under several axis and
// distance settings, with random gaps and stalls and one long output stall;
// a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LATENCY     = 59;
    localparam int SETTLE      = LATENCY + 12;
    localparam int WATCH_LIMIT = 3000;
    localparam int HOLD_CYCLES = 250;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;     // point_x, point_y, point_z
    logic         s_tuser;     // action
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;     // moved_x, moved_y, moved_z
    logic [1:0]   m_tuser;     // on_axis, saturated
    logic         cfg_we;
    logic [1:0]   cfg_addr;
    logic [31:0]  cfg_wdata;

    int pending;
    int fails;
    int quiet_cycles;
    bit no_idle;      // last part of the run: both sides stream back to back
    bit hold_req;     // ask the receiver for one long stall

    radial_point_offset DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    rpo_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .pending(pending), .fails(fails)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog: count cycles in which neither side moves an item
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // write the four registers on consecutive edges, then drop the enable
    task automatic write_regs(rpo_pkg::axis_t ax, rpo_pkg::axis_t ay, rpo_pkg::axis_t az,
                              rpo_pkg::coord_t shift_val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= rpo_pkg::REG_AXIS_X;
        cfg_wdata <= 32'(ax);
        @(posedge clk);
        cfg_addr <= rpo_pkg::REG_AXIS_Y;
        cfg_wdata <= 32'(ay);
        @(posedge clk);
        cfg_addr <= rpo_pkg::REG_AXIS_Z;
        cfg_wdata <= 32'(az);
        @(posedge clk);
        cfg_addr <= rpo_pkg::REG_SHIFT;
        cfg_wdata <= shift_val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // offer one item and hold it until taken; maybe idle after it
    task automatic send_point(logic act, rpo_pkg::coord_t px, rpo_pkg::coord_t py,
                              rpo_pkg::coord_t pz);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {pz, py, px};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic rpo_pkg::coord_t rand_coord();
        case ($urandom_range(0, 5))
            0: return rpo_pkg::coord_t'($urandom_range(0, 3) == 0 ? 32'h7fff_ffff
                                                                  : 32'h8000_0000);
            1: return rpo_pkg::coord_t'($urandom_range(0, 131072)) - 32'sd65536;
            2: return rpo_pkg::coord_t'($urandom_range(0, 1 << 24))
                      - rpo_pkg::coord_t'(1 << 23);
            default: return rpo_pkg::coord_t'($urandom);
        endcase
    endfunction

    function automatic rpo_pkg::axis_t rand_axis();
        case ($urandom_range(0, 4))
            0: return rpo_pkg::axis_t'(18'sd65536);
            1: return rpo_pkg::axis_t'(-18'sd65536);
            2: return rpo_pkg::axis_t'($urandom);     // full 18-bit value, out of range too
            default: return rpo_pkg::axis_t'($urandom_range(0, 131072) - 65536);
        endcase
    endfunction

    // wait for the pipe to drain before touching the registers
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic random_points(int count);
        rpo_pkg::coord_t k;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                // along the axis: exactly on it for a unit x axis setting
                k = rpo_pkg::coord_t'($urandom_range(0, 1 << 20))
                    - rpo_pkg::coord_t'(1 << 19);
                send_point(1'($urandom_range(0, 1)), k, 32'sd0, 32'sd0);
            end
            else
                send_point(1'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                           rand_coord());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = rpo_pkg::REG_AXIS_X;
        cfg_wdata = '0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        quiet_cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero axis and zero distance
        send_point(1'b0, 32'sd0, 32'sd0, 32'sd0);
        send_point(1'b1, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd65536);
        drain();

        // unit x axis, distance one: on-axis points and both actions
        write_regs(18'sd65536, 18'sd0, 18'sd0, 32'sd65536);
        send_point(1'b0, 32'sd0, 32'sd0, 32'sd0);
        send_point(1'b0, 32'sh7fff_ffff, 32'sd0, 32'sd0);
        send_point(1'b1, 32'sh8000_0000, 32'sd0, 32'sd0);
        send_point(1'b0, 32'sd65536, 32'sd65536, 32'sd0);
        send_point(1'b1, 32'sd65536, 32'sd0, -32'sd65536);
        send_point(1'b0, 32'sd5, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_point(1'b1, 32'sd5, 32'sh8000_0000, 32'sh8000_0000);
        send_point(1'b0, 32'sd0, 32'sd1, 32'sd0);
        drain();

        // largest distance: results clamp
        write_regs(18'sd0, 18'sd0, -18'sd65536, 32'sh7fff_ffff);
        send_point(1'b0, 32'sh7fff_ffff, 32'sd0, 32'sd3);
        send_point(1'b1, 32'sh8000_0000, 32'sh8000_0000, 32'sd0);
        send_point(1'b0, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff);
        drain();

        // smallest distance, axis registers beyond the unit range
        write_regs(18'sh1ffff, 18'sh20000, 18'sd46341, 32'sh8000_0000);
        send_point(1'b0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_point(1'b1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_point(1'b0, 32'sd1, -32'sd1, 32'sd1);
        random_points(60);
        drain();

        // unit x axis again for exact on-axis hits, with one long output stall
        write_regs(18'sd65536, 18'sd0, 18'sd0, rpo_pkg::coord_t'($urandom));
        random_points(40);
        hold_req = 1'b1;
        random_points(120);
        drain();

        // random settings
        for (int ph = 0; ph < 5; ph++)
        begin
            write_regs(rand_axis(), rand_axis(), rand_axis(),
                       ph == 0 ? 32'sd0 : rpo_pkg::coord_t'($urandom));
            random_points(50);
            drain();
        end

        // diagonal axis, no idling on either side
        write_regs(18'sd37837, 18'sd37837, -18'sd37837, 32'sd655360);
        no_idle = 1'b1;
        random_points(70);
        drain();

        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // receiver: random stalls, one long hold-off on request, none at the end
    initial
    begin
        int burst;
        m_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (no_idle)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                burst = $urandom_range(1, 9);
                m_tready <= 1'b0;
                repeat (burst) @(posedge clk);
            end
            else
            begin
                burst = $urandom_range(1, 20);
                m_tready <= 1'b1;
                repeat (burst) @(posedge clk);
            end
        end
    end

endmodule
